/* sv/rlcc_pkg.sv */
package rlcc_pkg;

  localparam int unsigned LINE_BYTES_DEF = 1024;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

  localparam logic [7:0] CH_DOLLAR = 8'h24;  // '$'
  localparam logic [7:0] CH_HASH   = 8'h23;  // '#'
  localparam logic [7:0] CH_STAR   = 8'h2A;  // '*'
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_NUL    = 8'h00;

  localparam logic [3:0] DIGITS_XOR = 4'd2;
  localparam logic [3:0] DIGITS_CRC = 4'd8;
  localparam logic [3:0] DIGITS_MAX = 4'd9;

  typedef enum logic [1:0] {
    VERDICT_XOR_GOOD  = 2'd0,
    VERDICT_CRC_GOOD  = 2'd1,
    VERDICT_MISMATCH  = 2'd2,
    VERDICT_MALFORMED = 2'd3
  } verdict_t;

  typedef struct packed {
    verdict_t    verdict;
    logic [9:0]  payload_length;
    logic [31:0] computed_check;
    logic [31:0] received_check;
  } rlcc_res_t;

  // reflected CRC-32, one byte, bitwise
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // {is_hex, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

endpackage

/* sv/rlcc_line.sv */
module rlcc_line import rlcc_pkg::*; #(
  parameter int unsigned LINE_BYTES = LINE_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  output logic       res_valid_o,
  output rlcc_res_t  res_o
);

  localparam int unsigned CW = $clog2(LINE_BYTES);
  localparam logic [CW-1:0] LAST_POS = CW'(LINE_BYTES - 1);

  logic [CW-1:0] count_r, count_nxt, c_count;
  logic [7:0]    xor_r, xor_nxt, c_xor;
  logic [31:0]   crc_r, crc_nxt, c_crc;
  logic [7:0]    sxor_r, sxor_nxt, c_sxor;
  logic [31:0]   scrc_r, scrc_nxt, c_scrc;
  logic          sseen_r, sseen_nxt, c_sseen;
  logic [CW-1:0] spos_r, spos_nxt, c_spos;
  logic [3:0]    dcnt_r, dcnt_nxt, c_dcnt;
  logic [31:0]   dval_r, dval_nxt, c_dval;
  logic          bad_r, bad_nxt, c_bad;
  logic          zero_r, zero_nxt, c_zero;

  logic          restart;
  logic [4:0]    hx;
  logic [CW-1:0] len_sel;
  logic [CW+9:0] len_ext;

  assign restart = (byte_i == CH_DOLLAR) || (byte_i == CH_HASH);
  assign hx      = hex_digit(byte_i);

  // state as seen after a leading restart
  always_comb begin
    c_count = restart ? '0    : count_r;
    c_xor   = restart ? '0    : xor_r;
    c_crc   = restart ? '0    : crc_r;
    c_sxor  = restart ? '0    : sxor_r;
    c_scrc  = restart ? '0    : scrc_r;
    c_sseen = restart ? 1'b0  : sseen_r;
    c_spos  = restart ? '0    : spos_r;
    c_dcnt  = restart ? '0    : dcnt_r;
    c_dval  = restart ? '0    : dval_r;
    c_bad   = restart ? 1'b0  : bad_r;
    c_zero  = restart ? 1'b0  : zero_r;
  end

  assign len_sel = c_sseen ? c_spos : c_count;
  assign len_ext = {10'd0, len_sel};

  always_comb begin
    count_nxt = count_r;  xor_nxt  = xor_r;  crc_nxt  = crc_r;
    sxor_nxt  = sxor_r;   scrc_nxt = scrc_r; sseen_nxt = sseen_r;
    spos_nxt  = spos_r;   dcnt_nxt = dcnt_r; dval_nxt = dval_r;
    bad_nxt   = bad_r;    zero_nxt = zero_r;
    res_valid_o = 1'b0;
    res_o = '{verdict: VERDICT_MALFORMED, payload_length: len_ext[9:0],
              computed_check: 32'd0, received_check: 32'd0};

    if (c_sseen && !c_bad && (c_dcnt == DIGITS_XOR || c_dcnt == DIGITS_CRC)) begin
      res_o.received_check = c_dval;
      if (c_dcnt == DIGITS_XOR) begin
        res_o.computed_check = {24'd0, c_sxor};
        res_o.verdict = ({24'd0, c_sxor} == c_dval) ? VERDICT_XOR_GOOD : VERDICT_MISMATCH;
      end else begin
        res_o.computed_check = c_scrc;
        res_o.verdict = (c_scrc == c_dval) ? VERDICT_CRC_GOOD : VERDICT_MISMATCH;
      end
    end

    if (step_i && byte_i != CH_CR) begin
      count_nxt = c_count;  xor_nxt  = c_xor;  crc_nxt  = c_crc;
      sxor_nxt  = c_sxor;   scrc_nxt = c_scrc; sseen_nxt = c_sseen;
      spos_nxt  = c_spos;   dcnt_nxt = c_dcnt; dval_nxt = c_dval;
      bad_nxt   = c_bad;    zero_nxt = c_zero;

      if (byte_i != CH_LF && c_count < LAST_POS) begin
        count_nxt = c_count + 1'b1;
        if (!c_zero) begin
          if (byte_i == CH_NUL) begin
            zero_nxt = 1'b1;
          end else begin
            if (byte_i == CH_STAR) begin
              sseen_nxt = 1'b1;
              spos_nxt  = c_count;
              sxor_nxt  = c_xor;
              scrc_nxt  = c_crc;
              dcnt_nxt  = '0;
              dval_nxt  = '0;
              bad_nxt   = 1'b0;
            end else if (c_sseen) begin
              if (!hx[4]) bad_nxt = 1'b1;
              else dval_nxt = {c_dval[27:0], hx[3:0]};
              if (c_dcnt < DIGITS_MAX) dcnt_nxt = c_dcnt + 1'b1;
            end
            xor_nxt = c_xor ^ byte_i;
            if (c_count != '0) crc_nxt = crc_byte(c_crc, byte_i);
          end
        end
      end else begin
        // line feed, or store full: emit if needed, then clear the line
        res_valid_o = (byte_i == CH_LF) && (c_count != '0);
        count_nxt = '0;  xor_nxt  = '0;  crc_nxt  = '0;
        sxor_nxt  = '0;  scrc_nxt = '0;  sseen_nxt = 1'b0;
        spos_nxt  = '0;  dcnt_nxt = '0;  dval_nxt = '0;
        bad_nxt   = 1'b0; zero_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;  xor_r  <= '0;  crc_r  <= '0;
      sxor_r  <= '0;  scrc_r <= '0;  sseen_r <= 1'b0;
      spos_r  <= '0;  dcnt_r <= '0;  dval_r <= '0;
      bad_r   <= 1'b0; zero_r <= 1'b0;
    end else begin
      count_r <= count_nxt; xor_r  <= xor_nxt;  crc_r   <= crc_nxt;
      sxor_r  <= sxor_nxt;  scrc_r <= scrc_nxt; sseen_r <= sseen_nxt;
      spos_r  <= spos_nxt;  dcnt_r <= dcnt_nxt; dval_r  <= dval_nxt;
      bad_r   <= bad_nxt;   zero_r <= zero_nxt;
    end
  end

endmodule

/* sv/receiver_line_checksum_check.sv */
// Line checksum checker for receiver text output. Bytes arrive one per
// transfer on the in_ channel; '$' or '#' starts a new line, carriage returns
// are skipped, and a line feed closes the line. A closed, non-empty line
// yields one out_ transfer: verdict 0 when two hex digits after the last '*'
// match the XOR of all bytes before it, 1 when eight hex digits match a
// reflected CRC-32 (poly 0xEDB88320, init 0, no final xor) over bytes two up
// to the star, 2 on a mismatch, 3 when there is no star or the digits are not
// exactly two or eight plain hex characters (both checks then read zero). A
// zero byte ends the text of a line; a byte that would fill the line store
// (LINE_BYTES-1 bytes held) drops the line and is itself dropped. Rate: one
// byte per clock while no result waits unaccepted; a line feed is held in
// the input register, its result in the output register. The byte-wide CRC
// step between the input register and the line state sets the clock-period
// path. While a result waits unaccepted in the output register the line
// logic holds; one more byte may enter the input register, then in_ready drops.
module receiver_line_checksum_check import rlcc_pkg::*; #(
  parameter int unsigned LINE_BYTES = LINE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_verdict,
  output logic [9:0]  out_payload_length,
  output logic [31:0] out_computed_check,
  output logic [31:0] out_received_check
);

  // input register
  logic       in_v_r;
  logic [7:0] in_b_r;

  // output register
  logic      out_v_r;
  rlcc_res_t out_r;

  logic      fire;       // registered byte is processed this cycle
  logic      res_valid;
  rlcc_res_t res;

  // a byte moves on when the output slot is free or being drained
  assign fire     = in_v_r && (!out_v_r || out_ready);
  assign in_ready = !in_v_r || fire;

  rlcc_line #(
    .LINE_BYTES (LINE_BYTES)
  ) u_line (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_i      (fire),
    .byte_i      (in_b_r),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_b_r <= in_rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (fire && res_valid) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid          = out_v_r;
  assign out_verdict        = out_r.verdict;
  assign out_payload_length = out_r.payload_length;
  assign out_computed_check = out_r.computed_check;
  assign out_received_check = out_r.received_check;

`ifndef SYNTHESIS
  // input stalls only behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without a blocked result");

  // a result is only produced by a line feed
  a_res_on_lf: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && res_valid) |-> (in_b_r == CH_LF))
    else $error("result from a byte other than line feed");

  // malformed lines carry zero checks
  a_malformed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_verdict == VERDICT_MALFORMED) |->
      (out_computed_check == 32'd0 && out_received_check == 32'd0))
    else $error("malformed verdict with nonzero checks");

  // a good XOR verdict means equal 8-bit values
  a_xor_good: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_verdict == VERDICT_XOR_GOOD) |->
      (out_computed_check == out_received_check && out_computed_check[31:8] == 24'd0))
    else $error("XOR good verdict with unequal checks");
`endif

endmodule
